/* hw/rtl/tst_pkg.sv */
// shared types, codes and constants of the two-region slot table
`timescale 1ns / 1ps

package tst_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int KEY_W     = 16;
    localparam int TAG_W     = KEY_W + 1;
    localparam int CNT_W     = 7;
    localparam int SLOT_W    = 6;

    localparam logic [CNT_W-1:0] SMALL_RST = 7'd32;
    localparam logic [CNT_W-1:0] TOTAL_RST = 7'd64;

    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_PROMOTE = 2'd2,
        CMD_FREE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_IS_BIG    = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REG_SMALL_COUNT = 1'b0,
        REG_TOTAL_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd             command;
        logic [KEY_W-1:0] conn_key;
    } t_cmd_beat;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_res_beat;

endpackage

/* hw/rtl/two_region_slot_table.sv */
// two-region slot table: key lookup, alloc, promote and free over one tag memory
//
// commands arrive as beats on the input channel (valid/ready), one result beat
// per command leaves on the output channel. the cfg port writes small_count
// (index 0) and total_count (index 1); the user is to write them only while
// the block is idle, which the block itself does not enforce.
// each command scans the active slots 0 .. lim_total-1 in ascending order,
// one memory read per cycle, where lim_total is total_count clamped to SLOTS,
// then passes through the write-back states WB1 and WB2.
// a new command is taken only in the idle state, after the previous one has
// placed its result in the output register.
// after reset the block clears all SLOTS slots of the tag memory, one slot a
// cycle, with input ready low; config writes are taken during that time.
// a finished result sits in the output register until taken; the next
// command is already accepted and scanned, and waits only to hand over its
// own result while the previous beat is stalled.
`timescale 1ns / 1ps

module two_region_slot_table #(
    parameter int SLOTS = tst_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tst_pkg::t_cmd_beat          i_in_beat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tst_pkg::t_res_beat          o_out_beat,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [tst_pkg::CNT_W-1:0]   i_cfg_data
);
    import tst_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [AW-1:0] LAST_A  = AW'(SLOTS - 1);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_SCAN = 6'b000100,
        S_WB1  = 6'b001000,
        S_WB2  = 6'b010000,
        S_RES  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_small, r_total;
    logic [AW:0]       r_cnt, n_cnt;
    logic              r_rd_vld, n_rd_vld;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    t_cmd              r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [CW-1:0]     r_lt, n_lt, r_ls, n_ls;
    logic              r_hit, n_hit, r_fs, n_fs, r_fb, n_fb;
    logic [AW-1:0]     r_hit_slot, n_hit_slot, r_fs_slot, n_fs_slot;
    logic [AW-1:0]     r_fb_slot, n_fb_slot;
    logic              r_w1_en, n_w1_en, r_w2_en, n_w2_en;
    logic [AW-1:0]     r_w1_addr, n_w1_addr, r_w2_addr, n_w2_addr;
    logic [TAG_W-1:0]  r_w1_data, n_w1_data;
    t_status           r_res_st, n_res_st;
    logic [AW-1:0]     r_res_slot, n_res_slot;
    logic              r_out_vld, n_out_vld;
    t_res_beat         r_out_beat, n_out_beat;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [TAG_W-1:0]  mem_wdata, mem_rdata;

    logic [CW-1:0]     cfg_small, cfg_total, lim_t, lim_s;
    logic              in_acc;

    assign cfg_small = CW'(r_small);
    assign cfg_total = CW'(r_total);
    assign lim_t     = (cfg_total > SLOTS_C) ? SLOTS_C : cfg_total;
    assign lim_s     = (cfg_small > lim_t) ? lim_t : cfg_small;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

    tst_tag_ram #(
        .SLOTS (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt[AW-1:0];
        mem_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_WB1: begin
                mem_we    = r_w1_en;
                mem_waddr = r_w1_addr;
                mem_wdata = r_w1_data;
            end
            S_WB2: begin
                mem_we    = r_w2_en;
                mem_waddr = r_w2_addr;
                mem_wdata = {1'b1, r_key};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_re    = (r_state == S_SCAN) && (CW'(r_cnt) < r_lt);
    assign mem_raddr = r_cnt[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_rd_vld   = 1'b0;
        n_rd_addr  = r_rd_addr;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_lt       = r_lt;
        n_ls       = r_ls;
        n_hit      = r_hit;
        n_hit_slot = r_hit_slot;
        n_fs       = r_fs;
        n_fs_slot  = r_fs_slot;
        n_fb       = r_fb;
        n_fb_slot  = r_fb_slot;
        n_w1_en    = r_w1_en;
        n_w1_addr  = r_w1_addr;
        n_w1_data  = r_w1_data;
        n_w2_en    = r_w2_en;
        n_w2_addr  = r_w2_addr;
        n_res_st   = r_res_st;
        n_res_slot = r_res_slot;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_beat = r_out_beat;

        unique case (r_state)
            S_CLR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[AW-1:0] == LAST_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_in_beat.command;
                    n_key   = i_in_beat.conn_key;
                    n_lt    = lim_t;
                    n_ls    = lim_s;
                    n_cnt   = '0;
                    n_hit   = 1'b0;
                    n_fs    = 1'b0;
                    n_fb    = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (mem_re) begin
                    n_cnt     = r_cnt + 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_cnt[AW-1:0];
                end
                // ascending scan, so a later match overwrites an earlier one
                if (r_rd_vld) begin
                    if (mem_rdata == {1'b1, r_key}) begin
                        n_hit      = 1'b1;
                        n_hit_slot = r_rd_addr;
                    end
                    if (!mem_rdata[TAG_W-1]) begin
                        if (CW'(r_rd_addr) < r_ls) begin
                            n_fs      = 1'b1;
                            n_fs_slot = r_rd_addr;
                        end else begin
                            n_fb      = 1'b1;
                            n_fb_slot = r_rd_addr;
                        end
                    end
                end
                if (!mem_re && !r_rd_vld) begin
                    n_state    = S_WB1;
                    n_w1_en    = 1'b0;
                    n_w1_addr  = r_hit_slot;
                    n_w1_data  = '0;
                    n_w2_en    = 1'b0;
                    n_w2_addr  = r_fb_slot;
                    n_res_st   = ST_OK;
                    n_res_slot = r_hit_slot;
                    unique case (r_cmd)
                        CMD_LOOKUP: begin
                            if (!r_hit) begin
                                n_res_st = ST_NOT_FOUND;
                            end
                        end
                        CMD_ALLOC: begin
                            if (!r_hit) begin
                                if (r_fs) begin
                                    n_w1_en    = 1'b1;
                                    n_w1_addr  = r_fs_slot;
                                    n_w1_data  = {1'b1, r_key};
                                    n_res_slot = r_fs_slot;
                                end else begin
                                    n_res_st = ST_NO_FREE;
                                end
                            end
                        end
                        CMD_PROMOTE: begin
                            if (!r_hit) begin
                                n_res_st = ST_NOT_FOUND;
                            end else if (CW'(r_hit_slot) >= r_ls) begin
                                n_res_st = ST_IS_BIG;
                            end else begin
                                // small slot is released even if no big slot is free
                                n_w1_en = 1'b1;
                                if (r_fb) begin
                                    n_w2_en    = 1'b1;
                                    n_res_slot = r_fb_slot;
                                end else begin
                                    n_res_st = ST_NO_FREE;
                                end
                            end
                        end
                        CMD_FREE: begin
                            if (!r_hit) begin
                                n_res_st = ST_NOT_FOUND;
                            end else begin
                                n_w1_en = 1'b1;
                            end
                        end
                        default: begin
                            n_res_st = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_WB1: begin
                n_state = S_WB2;
            end
            S_WB2: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld         = 1'b1;
                    n_out_beat.status = r_res_st;
                    n_out_beat.slot   = (r_res_st == ST_OK) ? SLOT_W'(r_res_slot) : '0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_small   <= SMALL_RST;
            r_total   <= TOTAL_RST;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_SMALL_COUNT: r_small <= i_cfg_data;
                    REG_TOTAL_COUNT: r_total <= i_cfg_data;
                    default: begin
                        r_small <= r_small;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_lt       <= n_lt;
        r_ls       <= n_ls;
        r_hit      <= n_hit;
        r_hit_slot <= n_hit_slot;
        r_fs       <= n_fs;
        r_fs_slot  <= n_fs_slot;
        r_fb       <= n_fb;
        r_fb_slot  <= n_fb_slot;
        r_w1_en    <= n_w1_en;
        r_w1_addr  <= n_w1_addr;
        r_w1_data  <= n_w1_data;
        r_w2_en    <= n_w2_en;
        r_w2_addr  <= n_w2_addr;
        r_res_st   <= n_res_st;
        r_res_slot <= n_res_slot;
        r_out_beat <= n_out_beat;
    end

    a_err_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != ST_OK) |-> (o_out_beat.slot == '0))
        else $error("result beat with error status carries a nonzero slot");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN))
        else $error("accepted command did not start a scan");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLR || r_state == S_WB1 || r_state == S_WB2))
        else $error("tag memory written outside clear or write-back");

    a_wb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WB1 || r_state == S_WB2) && mem_we) |-> (CW'(mem_waddr) < r_lt))
        else $error("write-back beyond the active slots");

endmodule

/* hw/rtl/tst_tag_ram.sv */
// slot tag memory: one write port, one read port, registered read data
`timescale 1ns / 1ps

module tst_tag_ram #(
    parameter int SLOTS = tst_pkg::SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(SLOTS)-1:0]   i_waddr,
    input  logic [tst_pkg::TAG_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(SLOTS)-1:0]   i_raddr,
    output logic [tst_pkg::TAG_W-1:0]  o_rdata
);
    import tst_pkg::*;

    logic [TAG_W-1:0] r_mem [SLOTS];
    logic [TAG_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule
